/* rtl/fpba_pkg.sv */
// ----------------------------------------------------------------------------
// fpba_pkg
// Types and constants shared by the fit-policy block allocator and its cells.
// ----------------------------------------------------------------------------
package fpba_pkg;

   localparam int MAX_BLOCKS_DEF = 16;
   localparam int SIZE_WIDTH_DEF = 16;
   localparam int PADDR_W        = 3;
   localparam int PDATA_W        = 32;

   localparam logic [4:0] BLOCK_COUNT_RESET = 5'd16;

   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_ALLOC = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      POL_FIRST = 2'd0,
      POL_NEXT  = 2'd1,
      POL_BEST  = 2'd2,
      POL_WORST = 2'd3
   } policy_type;

   typedef enum logic {
      REG_FIT_POLICY  = 1'b0,
      REG_BLOCK_COUNT = 1'b1
   } reg_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   typedef struct packed {
      func_type    func;
      logic [3:0]  block_index;
      logic [15:0] size_value;
   } req_word_type;

   typedef struct packed {
      logic        granted;
      logic [3:0]  chosen_block;
      logic [15:0] hole_after;
   } rsp_word_type;

   // search word flags handed from cell to cell
   typedef struct packed {
      logic valid;
      logic found_hi;
      logic found_lo;
   } chain_ctl_type;

endpackage

/* rtl/fpba_cell.sv */
// ----------------------------------------------------------------------------
// fpba_cell
// One block of the allocator: holds the block's hole and updates the search
// word as it passes through toward the next cell.
// ----------------------------------------------------------------------------
module fpba_cell #(
   parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
   parameter int SIZE_WIDTH = fpba_pkg::SIZE_WIDTH_DEF,
   parameter int CELL_INDEX = 0,
   localparam int IDX_W = $clog2(MAX_BLOCKS),
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fpba_pkg::func_type      func,
   input  fpba_pkg::policy_type    policy,
   input  logic [SIZE_WIDTH-1:0]   size,
   input  logic [IDX_W-1:0]        addr,
   input  logic [IDX_W-1:0]        start,
   input  logic [CNT_W-1:0]        count,
   input  logic                    wr_en,
   input  logic [IDX_W-1:0]        wr_idx,
   input  logic [SIZE_WIDTH-1:0]   wr_data,
   input  fpba_pkg::chain_ctl_type in_ctl,
   input  logic [IDX_W-1:0]        in_pick_hi,
   input  logic [SIZE_WIDTH-1:0]   in_hole_hi,
   input  logic [IDX_W-1:0]        in_pick_lo,
   input  logic [SIZE_WIDTH-1:0]   in_hole_lo,
   output fpba_pkg::chain_ctl_type out_ctl,
   output logic [IDX_W-1:0]        out_pick_hi,
   output logic [SIZE_WIDTH-1:0]   out_hole_hi,
   output logic [IDX_W-1:0]        out_pick_lo,
   output logic [SIZE_WIDTH-1:0]   out_hole_lo
);
   import fpba_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);
   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_INDEX);

   logic [SIZE_WIDTH-1:0] hole_ff;

   chain_ctl_type         ctl_ff, ctl_in;
   logic [IDX_W-1:0]      pick_hi_ff, pick_hi_in, pick_lo_ff, pick_lo_in;
   logic [SIZE_WIDTH-1:0] hole_hi_ff, hole_hi_in, hole_lo_ff, hole_lo_in;

   logic fits;
   logic after_start;

   always_ff @(posedge clock) begin
      if (wr_en && (wr_idx == MY_IDX)) begin
         hole_ff <= wr_data;
      end
   end

   assign fits        = (MY_CNT < count) && (hole_ff >= size);
   assign after_start = (MY_IDX >= start);

   always_comb begin
      ctl_in     = in_ctl;
      pick_hi_in = in_pick_hi;
      hole_hi_in = in_hole_hi;
      pick_lo_in = in_pick_lo;
      hole_lo_in = in_hole_lo;
      case (func)
         FUNC_ALLOC: begin
            case (policy)
               POL_FIRST: begin
                  if (fits && !in_ctl.found_hi) begin
                     ctl_in.found_hi = 1'b1;
                     pick_hi_in      = MY_IDX;
                     hole_hi_in      = hole_ff;
                  end
               end
               POL_NEXT: begin
                  if (fits && after_start && !in_ctl.found_hi) begin
                     ctl_in.found_hi = 1'b1;
                     pick_hi_in      = MY_IDX;
                     hole_hi_in      = hole_ff;
                  end
                  if (fits && !after_start && !in_ctl.found_lo) begin
                     ctl_in.found_lo = 1'b1;
                     pick_lo_in      = MY_IDX;
                     hole_lo_in      = hole_ff;
                  end
               end
               POL_BEST: begin
                  if (fits && (!in_ctl.found_hi || (hole_ff < in_hole_hi))) begin
                     ctl_in.found_hi = 1'b1;
                     pick_hi_in      = MY_IDX;
                     hole_hi_in      = hole_ff;
                  end
               end
               POL_WORST: begin
                  if (fits && (!in_ctl.found_hi || (hole_ff > in_hole_hi))) begin
                     ctl_in.found_hi = 1'b1;
                     pick_hi_in      = MY_IDX;
                     hole_hi_in      = hole_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         FUNC_READ: begin
            if (addr == MY_IDX) begin
               hole_hi_in = hole_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      pick_hi_ff <= pick_hi_in;
      hole_hi_ff <= hole_hi_in;
      pick_lo_ff <= pick_lo_in;
      hole_lo_ff <= hole_lo_in;
   end

   assign out_ctl     = ctl_ff;
   assign out_pick_hi = pick_hi_ff;
   assign out_hole_hi = hole_hi_ff;
   assign out_pick_lo = pick_lo_ff;
   assign out_hole_lo = hole_lo_ff;

endmodule

/* rtl/fit_policy_block_allocator.sv */
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Hole table with first, next, best and worst fit allocation over a chain
// of block cells.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    req_word  (func, block_index, size)
//  rsp      out        rsp_valid/stall    rsp_word  (granted, block, hole)
//  csr      in         psel/penable/...   fit_policy @0, block_count @4
//
//  Every word, of any func, travels the cell chain once: one cell per cycle.
//  An item goes from acceptance through the launch register, the cell chain
//  and the pending result register into the output register; the next word
//  is taken only after that load; rsp_stall may still hold that result.
//  Reset clears control, next fit pointer and registers; holes are unknown
//  until loaded.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator #(
   parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
   parameter int SIZE_WIDTH = fpba_pkg::SIZE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  fpba_pkg::req_word_type         req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output fpba_pkg::rsp_word_type         rsp_word,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fpba_pkg::PADDR_W-1:0]   paddr,
   input  logic [fpba_pkg::PDATA_W-1:0]   pwdata,
   output logic [fpba_pkg::PDATA_W-1:0]   prdata,
   output logic                           pready
);
   import fpba_pkg::*;

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

   policy_type fit_policy_ff;
   logic [4:0] block_count_ff;
   logic       cfg_write;

   state_type  state_ff, state_in;

   func_type              func_ff;
   logic [3:0]            bidx_ff;
   logic [IDX_W-1:0]      addr_ff, addr_mod;
   logic [SIZE_WIDTH-1:0] size_ff;
   logic [IDX_W-1:0]      start_ff;
   logic [CNT_W-1:0]      count_ff, count_sat;
   logic [IDX_W-1:0]      next_start_ff;
   logic                  launch_ff;
   logic                  accept;

   chain_ctl_type         chain_ctl [0:MAX_BLOCKS];
   logic [IDX_W-1:0]      chain_pick_hi [0:MAX_BLOCKS];
   logic [SIZE_WIDTH-1:0] chain_hole_hi [0:MAX_BLOCKS];
   logic [IDX_W-1:0]      chain_pick_lo [0:MAX_BLOCKS];
   logic [SIZE_WIDTH-1:0] chain_hole_lo [0:MAX_BLOCKS];
   logic [MAX_BLOCKS:0]   chain_valid;

   chain_ctl_type         exit_ctl;
   logic                  sel_found;
   logic [IDX_W-1:0]      sel_pick;
   logic [SIZE_WIDTH-1:0] sel_hole, remain;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_idx;
   logic [SIZE_WIDTH-1:0] wr_data;

   rsp_word_type          result;
   rsp_word_type          pend_ff;
   rsp_word_type          rsp_word_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_load;

   // configuration port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_policy_ff  <= POL_FIRST;
         block_count_ff <= BLOCK_COUNT_RESET;
      end else if (cfg_write) begin
         case (reg_sel_type'(paddr[2]))
            REG_FIT_POLICY:  fit_policy_ff  <= policy_type'(pwdata[1:0]);
            REG_BLOCK_COUNT: block_count_ff <= pwdata[4:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel_type'(paddr[2]))
         REG_FIT_POLICY:  prdata = {(PDATA_W - 2)'(0), fit_policy_ff};
         REG_BLOCK_COUNT: prdata = {(PDATA_W - 5)'(0), block_count_ff};
         default:         prdata = '0;
      endcase
   end

   // item intake
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      if (32'(block_count_ff) > 32'(MAX_BLOCKS)) begin
         count_sat = CNT_W'(MAX_BLOCKS);
      end else begin
         count_sat = CNT_W'(block_count_ff);
      end
   end

   always_comb begin
      addr_mod = '0;
      for (int v = 0; v < 16; v++) begin
         if (req_word.block_index == 4'(v)) begin
            addr_mod = IDX_W'(v % MAX_BLOCKS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_word.func;
         bidx_ff  <= req_word.block_index;
         addr_ff  <= addr_mod;
         size_ff  <= SIZE_WIDTH'(req_word.size_value);
         count_ff <= count_sat;
         if (CNT_W'(next_start_ff) < count_sat) begin
            start_ff <= next_start_ff;
         end else begin
            start_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ff <= 1'b0;
      end else begin
         launch_ff <= accept;
      end
   end

   // cell chain
   assign chain_ctl[0]     = '{valid: launch_ff, found_hi: 1'b0, found_lo: 1'b0};
   assign chain_pick_hi[0] = '0;
   assign chain_hole_hi[0] = '0;
   assign chain_pick_lo[0] = '0;
   assign chain_hole_lo[0] = '0;

   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      fpba_cell #(
         .MAX_BLOCKS (MAX_BLOCKS),
         .SIZE_WIDTH (SIZE_WIDTH),
         .CELL_INDEX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .func        (func_ff),
         .policy      (fit_policy_ff),
         .size        (size_ff),
         .addr        (addr_ff),
         .start       (start_ff),
         .count       (count_ff),
         .wr_en       (wr_en),
         .wr_idx      (wr_idx),
         .wr_data     (wr_data),
         .in_ctl      (chain_ctl[i]),
         .in_pick_hi  (chain_pick_hi[i]),
         .in_hole_hi  (chain_hole_hi[i]),
         .in_pick_lo  (chain_pick_lo[i]),
         .in_hole_lo  (chain_hole_lo[i]),
         .out_ctl     (chain_ctl[i+1]),
         .out_pick_hi (chain_pick_hi[i+1]),
         .out_hole_hi (chain_hole_hi[i+1]),
         .out_pick_lo (chain_pick_lo[i+1]),
         .out_hole_lo (chain_hole_lo[i+1])
      );
   end

   for (genvar i = 0; i <= MAX_BLOCKS; i++) begin : g_valid
      assign chain_valid[i] = chain_ctl[i].valid;
   end

   // chain exit: pick, write back, result
   assign exit_ctl  = chain_ctl[MAX_BLOCKS];
   assign sel_found = exit_ctl.found_hi || exit_ctl.found_lo;
   assign sel_pick  = exit_ctl.found_hi ? chain_pick_hi[MAX_BLOCKS]
                                        : chain_pick_lo[MAX_BLOCKS];
   assign sel_hole  = exit_ctl.found_hi ? chain_hole_hi[MAX_BLOCKS]
                                        : chain_hole_lo[MAX_BLOCKS];
   assign remain    = sel_hole - size_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = sel_pick;
      wr_data = remain;
      result  = '{granted: 1'b0, chosen_block: bidx_ff, hole_after: 16'(0)};
      case (func_ff)
         FUNC_LOAD: begin
            wr_en   = exit_ctl.valid;
            wr_idx  = addr_ff;
            wr_data = size_ff;
            result  = '{granted: 1'b1, chosen_block: 4'(addr_ff),
                        hole_after: 16'(size_ff)};
         end
         FUNC_READ: begin
            result = '{granted: 1'b1, chosen_block: 4'(addr_ff),
                       hole_after: 16'(chain_hole_hi[MAX_BLOCKS])};
         end
         FUNC_ALLOC: begin
            wr_en = exit_ctl.valid && sel_found;
            if (sel_found) begin
               result = '{granted: 1'b1, chosen_block: 4'(sel_pick),
                          hole_after: 16'(remain)};
            end else begin
               result = '{granted: 1'b0, chosen_block: 4'(0), hole_after: 16'(0)};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_start_ff <= '0;
      end else if (exit_ctl.valid && (func_ff == FUNC_ALLOC) && sel_found &&
                   (fit_policy_ff == POL_NEXT)) begin
         next_start_ff <= sel_pick;
      end
   end

   always_ff @(posedge clock) begin
      if (exit_ctl.valid) begin
         pend_ff <= result;
      end
   end

   // control
   assign rsp_load = (state_ff == ST_HOLD) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept)         state_in = ST_RUN;
         ST_RUN:  if (exit_ctl.valid) state_in = ST_HOLD;
         ST_HOLD: if (rsp_load)       state_in = ST_IDLE;
         default:                     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_word_ff <= pend_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // checks
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      $onehot0(chain_valid))
      else $error("more than one word in the cell chain");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (chain_valid == '0))
      else $error("cell chain busy while idle");

   a_exit_run: assert property (@(posedge clock) disable iff (reset)
      exit_ctl.valid |-> (state_ff == ST_RUN))
      else $error("chain exit outside run state");

   a_write_exit: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> exit_ctl.valid)
      else $error("hole write without chain exit");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      exit_ctl.valid |=> (state_ff == ST_HOLD))
      else $error("result not held after chain exit");

endmodule
